>>> sv/cfcv_pkg.sv
// Package for the complex FIR full convolution block.
// Holds the sizes, payload types, opcodes and the lane control struct.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package cfcv_pkg;

  // Number of coefficient slots and of filter lanes.
  localparam int TAPS   = 8;
  localparam int HIST   = TAPS - 1;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 3;
  localparam int SMP_W  = 16;
  localparam int PROD_W = 2 * SMP_W;
  localparam int ACC_W  = 35;
  localparam int TC_W   = 4;

  // Tail counter, active tap count and adder tree shape.
  localparam int TAIL_W = $clog2(TAPS);
  localparam int NACT_W = $clog2(TAPS + 1);
  localparam int LVL    = $clog2(TAPS);
  localparam int NPAD   = 1 << LVL;

  typedef logic signed [SMP_W-1:0]  q15_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [TC_W-1:0]          tap_cnt_t;
  typedef logic [OP_W-1:0]          op_bits_t;
  typedef logic [IDX_W-1:0]         tap_idx_t;

  localparam tap_cnt_t TAP_COUNT_RST = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  // Control that travels with the lane products into the adder tree.
  typedef struct packed {
    logic vld;
    logic last;
  } lane_ctl_t;

endpackage

`default_nettype wire

>>> sv/cfcv_in_if.sv
// Input channel of the convolution block: valid/ready plus the item fields.
// Depends on cfcv_pkg for the field types.
`default_nettype none

interface cfcv_in_if;
  import cfcv_pkg::*;

  logic     valid;
  logic     ready;
  op_bits_t opcode;
  tap_idx_t tap_index;
  q15_t     coef_value;
  q15_t     sample_real;
  q15_t     sample_imag;

  modport source (
    output valid, opcode, tap_index, coef_value, sample_real, sample_imag,
    input  ready
  );

  modport sink (
    input  valid, opcode, tap_index, coef_value, sample_real, sample_imag,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/cfcv_out_if.sv
// Output channel of the convolution block: valid/ready plus the result fields.
// Depends on cfcv_pkg for the field types.
`default_nettype none

interface cfcv_out_if;
  import cfcv_pkg::*;

  logic valid;
  logic ready;
  acc_t out_real;
  acc_t out_imag;
  logic last;

  modport source (
    output valid, out_real, out_imag, last,
    input  ready
  );

  modport sink (
    input  valid, out_real, out_imag, last,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/cfcv_lane.sv
// One filter lane: real and imaginary sample times one coefficient.
// Depends on cfcv_pkg; instantiated once per tap by the top level.
`default_nettype none

module cfcv_lane (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic          use_i,
  input  wire cfcv_pkg::q15_t coef_i,
  input  wire cfcv_pkg::q15_t smp_re_i,
  input  wire cfcv_pkg::q15_t smp_im_i,
  output cfcv_pkg::prod_t    prod_re_o,
  output cfcv_pkg::prod_t    prod_im_o
);
  import cfcv_pkg::*;

  prod_t prod_re_q, prod_re_d;
  prod_t prod_im_q, prod_im_d;

  // A tap beyond the active count contributes nothing to the sum.
  always_comb begin
    if (use_i) begin
      prod_re_d = prod_t'(smp_re_i) * prod_t'(coef_i);
      prod_im_d = prod_t'(smp_im_i) * prod_t'(coef_i);
    end else begin
      prod_re_d = '0;
      prod_im_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_re_q <= prod_re_d;
      prod_im_q <= prod_im_d;
    end
  end

  assign prod_re_o = prod_re_q;
  assign prod_im_o = prod_im_q;

endmodule

`default_nettype wire

>>> sv/cfcv_merge.sv
// Registered adder tree that merges the lane products into one result pair.
// Depends on cfcv_pkg and cfcv_out_if; its last level is the output register.
`default_nettype none

module cfcv_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfcv_pkg::lane_ctl_t ctl_i,
  input  wire cfcv_pkg::prod_t    prod_re_i [cfcv_pkg::TAPS],
  input  wire cfcv_pkg::prod_t    prod_im_i [cfcv_pkg::TAPS],
  output logic                    take_o,
  cfcv_out_if.source              out_o
);
  import cfcv_pkg::*;

  // Tree nodes in heap order: node 1 is the root, node i has children 2i
  // and 2i+1, and indexes from NPAD upward are the lane products.
  acc_t heap_re_q [1:NPAD-1];
  acc_t heap_im_q [1:NPAD-1];

  logic [LVL:1]   v_q;
  logic [LVL:1]   l_q;
  logic [LVL+1:1] en;

  assign en[LVL+1] = out_o.ready;

  for (genvar s = 1; s <= LVL; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      l_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= ctl_i.vld;
        l_q[1] <= ctl_i.last;
      end
      for (int s = 2; s <= LVL; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
          l_q[s] <= l_q[s-1];
        end
      end
    end
  end

  for (genvar i = 1; i < NPAD; i++) begin : g_node
    localparam int D = $clog2(i + 1) - 1;
    localparam int S = LVL - D;
    acc_t a_re, b_re, a_im, b_im;

    if (2 * i >= NPAD) begin : g_leaf
      localparam int J0 = 2 * i - NPAD;
      localparam int J1 = J0 + 1;
      if (J0 < TAPS) begin : g_a
        assign a_re = ACC_W'(prod_re_i[J0]);
        assign a_im = ACC_W'(prod_im_i[J0]);
      end else begin : g_a0
        assign a_re = '0;
        assign a_im = '0;
      end
      if (J1 < TAPS) begin : g_b
        assign b_re = ACC_W'(prod_re_i[J1]);
        assign b_im = ACC_W'(prod_im_i[J1]);
      end else begin : g_b0
        assign b_re = '0;
        assign b_im = '0;
      end
    end else begin : g_inner
      assign a_re = heap_re_q[2*i];
      assign b_re = heap_re_q[2*i+1];
      assign a_im = heap_im_q[2*i];
      assign b_im = heap_im_q[2*i+1];
    end

    // Sums wrap at the output width, which matches the exact sum modulo 2^35.
    always_ff @(posedge clk_i) begin
      if (en[S]) begin
        heap_re_q[i] <= a_re + b_re;
        heap_im_q[i] <= a_im + b_im;
      end
    end
  end

  assign take_o         = en[1];
  assign out_o.valid    = v_q[LVL];
  assign out_o.last     = l_q[LVL];
  assign out_o.out_real = heap_re_q[1];
  assign out_o.out_imag = heap_im_q[1];

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.vld && en[1]) |=> v_q[1])
    else $error("lane result was not taken into the tree");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l_q[LVL] && !v_q[LVL]) |-> en[LVL])
    else $error("inconsistent tree stage flags");

endmodule

`default_nettype wire

>>> sv/complex_fir_full_convolution_core.sv
// Top level of the complex FIR full convolution block.
// Depends on cfcv_pkg, cfcv_in_if, cfcv_out_if, cfcv_lane and cfcv_merge.
`default_nettype none

// The block convolves a real or complex Q1.15 sample stream with a real
// filter of up to TAPS Q1.15 coefficients and returns exact 35-bit sums for
// the real and the imaginary part. Load and sample items are taken one per
// clock, back to back, while no flush runs and the tree has room; each
// sample gives one result. A flush item blocks the input while it feeds
// tap_count-1 zero samples into the lanes, marks the last tail result and
// clears the history; with one tap it gives no result and only clears. A
// result passes the lane multiplier registers and then each level of the
// registered adder tree, whose root is the output register. Bubbles in that
// tree absorb a stalled output, so new items are still taken while a result
// waits, until the tree is full. After reset the block is ready at once;
// tap_count is 8 and coefficients and history are zero.

module complex_fir_full_convolution_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire cfcv_pkg::tap_cnt_t cfg_wdata_i,
  cfcv_in_if.sink                 in_i,
  cfcv_out_if.source              out_o
);
  import cfcv_pkg::*;

  // Configuration and filter state.
  tap_cnt_t tap_count_q;
  q15_t     coef_q    [TAPS];
  q15_t     hist_re_q [HIST];
  q15_t     hist_im_q [HIST];

  // Flush sequencer: busy while tail samples are being injected.
  logic              busy_q;
  logic [TAIL_W-1:0] remain_q;

  // Lane stage control.
  lane_ctl_t lane_ctl_q;

  logic              take;
  logic              en0;
  logic              acc;
  logic              cmd_load, cmd_sample, cmd_flush;
  logic [NACT_W-1:0] n_act;
  logic [TAIL_W-1:0] tail;
  logic              push, push_last, clear_now;
  q15_t              push_re, push_im;
  logic [TAPS-1:0]   use_tap;

  prod_t prod_re [TAPS];
  prod_t prod_im [TAPS];

  // The lane registers move whenever they are empty or the tree takes them.
  assign en0        = !lane_ctl_q.vld || take;
  assign in_i.ready = !busy_q && en0;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    cmd_load   = 1'b0;
    cmd_sample = 1'b0;
    cmd_flush  = 1'b0;
    unique case (op_e'(in_i.opcode))
      OP_LOAD:   cmd_load   = acc;
      OP_SAMPLE: cmd_sample = acc;
      OP_FLUSH:  cmd_flush  = acc;
      default:   ;
    endcase
  end

  // Out-of-range tap counts are clamped to the valid range.
  always_comb begin
    if (tap_count_q == '0) begin
      n_act = NACT_W'(1);
    end else if (int'(tap_count_q) > TAPS) begin
      n_act = NACT_W'(TAPS);
    end else begin
      n_act = NACT_W'(tap_count_q);
    end
  end

  assign tail = TAIL_W'(n_act - 1'b1);

  // A push enters one sample into the lanes: a real one, or a zero of a flush.
  assign push      = cmd_sample || (busy_q && en0);
  assign push_last = busy_q && (remain_q == TAIL_W'(1));
  assign push_re   = busy_q ? q15_t'(0) : in_i.sample_real;
  assign push_im   = busy_q ? q15_t'(0) : in_i.sample_imag;
  assign clear_now = cmd_flush && (tail == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        coef_q[k] <= '0;
      end
    end else if (cmd_load && (int'(in_i.tap_index) < TAPS)) begin
      coef_q[in_i.tap_index[TAIL_W-1:0]] <= in_i.coef_value;
    end
  end

  // History shifts on every push; the final tail push and a single-tap
  // flush leave it cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST; k++) begin
        hist_re_q[k] <= '0;
        hist_im_q[k] <= '0;
      end
    end else if ((push && push_last) || clear_now) begin
      for (int k = 0; k < HIST; k++) begin
        hist_re_q[k] <= '0;
        hist_im_q[k] <= '0;
      end
    end else if (push) begin
      for (int k = HIST - 1; k > 0; k--) begin
        hist_re_q[k] <= hist_re_q[k-1];
        hist_im_q[k] <= hist_im_q[k-1];
      end
      hist_re_q[0] <= push_re;
      hist_im_q[0] <= push_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      remain_q <= '0;
    end else if (busy_q) begin
      if (en0) begin
        remain_q <= remain_q - 1'b1;
        if (push_last) begin
          busy_q <= 1'b0;
        end
      end
    end else if (cmd_flush && (tail != '0)) begin
      busy_q   <= 1'b1;
      remain_q <= tail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_ctl_q <= '0;
    end else if (en0) begin
      lane_ctl_q.vld  <= push;
      lane_ctl_q.last <= push && push_last;
    end
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_lane
    assign use_tap[k] = (NACT_W'(k) < n_act);

    if (k == 0) begin : g_new
      cfcv_lane u_lane (
        .clk_i     (clk_i),
        .en_i      (push),
        .use_i     (use_tap[k]),
        .coef_i    (coef_q[k]),
        .smp_re_i  (push_re),
        .smp_im_i  (push_im),
        .prod_re_o (prod_re[k]),
        .prod_im_o (prod_im[k])
      );
    end else begin : g_old
      cfcv_lane u_lane (
        .clk_i     (clk_i),
        .en_i      (push),
        .use_i     (use_tap[k]),
        .coef_i    (coef_q[k]),
        .smp_re_i  (hist_re_q[k-1]),
        .smp_im_i  (hist_im_q[k-1]),
        .prod_re_o (prod_re[k]),
        .prod_im_o (prod_im[k])
      );
    end
  end

  cfcv_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (lane_ctl_q),
    .prod_re_i (prod_re),
    .prod_im_i (prod_im),
    .take_o    (take),
    .out_o     (out_o)
  );

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_i.ready)
    else $error("input taken during a flush");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (remain_q != '0))
    else $error("flush sequencer busy with no tail left");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((push && push_last) || clear_now) |=>
      (hist_re_q[0] == '0) && (hist_im_q[0] == '0) && !busy_q)
    else $error("history not cleared at the end of a flush");

  a_last_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctl_q.last |-> lane_ctl_q.vld)
    else $error("last flag without a lane result");

endmodule

`default_nettype wire
